// ===== rtl/utf8pm_pkg.sv =====
package utf8pm_pkg;

	// default width of the byte and unit counters
	localparam int COUNT_WIDTH_DEF = 16;
	// width of the fixed payload fields
	localparam int FIELD_W = 16;
	// entries in the queue between classifier and counters
	localparam int QUEUE_DEPTH = 2;
	// register map, by index
	localparam int REG_ENCODING = 0;
	// top bit of a byte: clear for ASCII
	localparam logic [7:0] ASCII_MASK = 8'h80;

	typedef enum logic [1:0] {
		MODE_UTF8  = 2'd0,
		MODE_UTF16 = 2'd1,
		MODE_UTF32 = 2'd2,
		MODE_ALT32 = 2'd3
	} enc_mode_t;

	// one classified beat, handed from front to back
	typedef struct packed {
		logic        has_byte;
		logic        first_item;
		logic        last_item;
		logic [15:0] target_units;
		logic        lead;
		logic [2:0]  seq_len;
		logic [1:0]  unit_step;
		logic        count_units;
	} cls_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// sequence length from the lead byte's leading ones; others count as one
	function automatic logic [2:0] seq_len_of(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd1;
		if ((b & ASCII_MASK) != 8'h00) begin
			if (b[7:5] == 3'b110)
				len = 3'd2;
			else if (b[7:4] == 4'b1110)
				len = 3'd3;
			else if (b[7:3] == 5'b11110)
				len = 3'd4;
		end
		return len;
	endfunction

endpackage

// ===== rtl/utf8pm_if.sv =====
// byte stream channel
interface utf8pm_byte_if;
	logic        valid;
	logic        ready;
	logic        has_byte;
	logic [7:0]  data_byte;
	logic        first_item;
	logic        last_item;
	logic [15:0] target_units;

	modport source (
		output valid, has_byte, data_byte, first_item, last_item, target_units,
		input  ready
	);
	modport sink (
		input  valid, has_byte, data_byte, first_item, last_item, target_units,
		output ready
	);
endinterface

// result channel
interface utf8pm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] byte_offset;
	logic        offset_valid;
	logic [15:0] unit_count;
	logic        count_saturated;

	modport source (
		output valid, byte_offset, offset_valid, unit_count, count_saturated,
		input  ready
	);
	modport sink (
		input  valid, byte_offset, offset_valid, unit_count, count_saturated,
		output ready
	);
endinterface

// ===== rtl/utf8_position_unit_measure_top.sv =====
// Scans a line of UTF-8 text one byte per beat and converts a target count of
// units (UTF-8 bytes, UTF-16 units or codepoints, per the encoding register at
// byte address 0) into a byte offset, reporting it with the text's total unit
// count on the beat marked last_item. One byte is taken every clock cycle while
// the queue is not full; the rate is set by the counter stage, which updates all
// counters for one byte per cycle unless a last beat waits on an untaken result.
// result.valid is registered: the last byte's beat is written into the
// classifier-to-counter queue and, when the counter stage pops it, loads the
// output register. The input keeps flowing while a result waits, until the
// two-entry queue fills. The byte and unit counters saturate at 2^COUNT_WIDTH-1,
// the offset accumulator at 2^(COUNT_WIDTH+1)-1; each sets count_saturated.
// Write the encoding register only while no text is in flight.
module utf8_position_unit_measure_top #(
	parameter int COUNT_WIDTH = utf8pm_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	utf8pm_byte_if.sink bytes,
	utf8pm_result_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	utf8pm_pkg::enc_mode_t   mode_q;
	utf8pm_pkg::cls_item_t   front_item;
	utf8pm_pkg::cls_item_t   back_item;
	utf8pm_pkg::queue_stat_t q_stat;
	logic                    push;
	logic                    pop;
	logic                    reg_hit;

	// register port
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'(utf8pm_pkg::REG_ENCODING));
	assign prdata  = reg_hit ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= utf8pm_pkg::MODE_UTF16;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			mode_q <= utf8pm_pkg::enc_mode_t'(pwdata[1:0]);
		end
	end

	utf8pm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.mode   (mode_q),
		.q_full (q_stat.full),
		.item   (front_item),
		.push   (push)
	);

	utf8pm_queue #(
		.DEPTH (utf8pm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (back_item),
		.stat    (q_stat)
	);

	utf8pm_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mode    (mode_q),
		.item    (back_item),
		.q_empty (q_stat.empty),
		.pop     (pop),
		.result  (result)
	);

	// a new result only follows a last beat leaving the queue
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(pop && back_item.last_item))
		else $error("result raised without a last beat");

	// the counter stage never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// queue cannot be both empty and full
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.empty && q_stat.full))
		else $error("queue status inconsistent");

endmodule

// ===== rtl/utf8pm_front.sv =====
module utf8pm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	utf8pm_byte_if.sink           bytes,
	input  utf8pm_pkg::enc_mode_t mode,
	input  logic                  q_full,
	output utf8pm_pkg::cls_item_t item,
	output logic                  push
);

	logic [1:0] skip_q;
	logic [1:0] skip_base;
	logic [1:0] skip_next;
	logic [2:0] len;

	assign bytes.ready = !q_full;
	assign push        = bytes.valid && !q_full;

	// classify the beat: trailing bytes are skipped, leads give length and units
	always_comb begin
		skip_base = bytes.first_item ? 2'd0 : skip_q;
		len       = utf8pm_pkg::seq_len_of(bytes.data_byte);

		item.has_byte     = bytes.has_byte;
		item.first_item   = bytes.first_item;
		item.last_item    = bytes.last_item;
		item.target_units = bytes.target_units;
		item.lead         = bytes.has_byte && (skip_base == 2'd0);
		item.seq_len      = len;
		item.unit_step    = ((len == 3'd4) && (mode == utf8pm_pkg::MODE_UTF16)) ? 2'd2 : 2'd1;
		item.count_units  = item.lead && (mode != utf8pm_pkg::MODE_UTF8);

		skip_next = skip_base;
		if (bytes.has_byte) begin
			if (skip_base != 2'd0)
				skip_next = skip_base - 2'd1;
			else
				skip_next = 2'(len - 3'd1);
		end
	end

	// trailing bytes still to skip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 2'd0;
		end else if (push) begin
			skip_q <= skip_next;
		end
	end

endmodule

// ===== rtl/utf8pm_queue.sv =====
module utf8pm_queue #(
	parameter int DEPTH = utf8pm_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  utf8pm_pkg::cls_item_t   wr_item,
	input  logic                    pop,
	output utf8pm_pkg::cls_item_t   rd_item,
	output utf8pm_pkg::queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8pm_pkg::cls_item_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign rd_item    = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_item;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/utf8pm_back.sv =====
module utf8pm_back #(
	parameter int COUNT_WIDTH = utf8pm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utf8pm_pkg::enc_mode_t mode,
	input  utf8pm_pkg::cls_item_t item,
	input  logic                  q_empty,
	output logic                  pop,
	utf8pm_result_if.source       result
);

	localparam int CW    = COUNT_WIDTH;
	localparam int CMP_W = (CW + 1 > 18) ? CW + 1 : 18;
	localparam int FW    = utf8pm_pkg::FIELD_W;
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};
	localparam logic [CW:0]   AMAX = {(CW + 1){1'b1}};

	logic [CW-1:0]      bytes_seen_q;
	logic [CW:0]        offset_accum_q;
	logic signed [17:0] units_left_q;
	logic               reached_q;
	logic [CW-1:0]      total_q;
	logic               sat_q;

	logic               res_valid_q;
	logic [FW-1:0]      res_offset_q;
	logic               res_ok_q;
	logic [FW-1:0]      res_count_q;
	logic               res_sat_q;

	logic [CW-1:0]      bytes_n;
	logic [CW:0]        accum_n;
	logic signed [17:0] units_n;
	logic               reached_n;
	logic [CW-1:0]      total_n;
	logic               sat_n;
	logic [CW:0]        tot_sum;
	logic [CW+1:0]      acc_sum;
	logic [CMP_W-1:0]   off;
	logic [CMP_W-1:0]   seen_ext;
	logic [CMP_W-1:0]   tot_ext;
	logic               ok;

	assign pop = !q_empty && (!item.last_item || !res_valid_q || result.ready);

	// counter update for the beat at the head of the queue
	always_comb begin
		bytes_n   = item.first_item ? '0 : bytes_seen_q;
		accum_n   = item.first_item ? '0 : offset_accum_q;
		units_n   = item.first_item ? $signed({2'b00, item.target_units}) : units_left_q;
		reached_n = item.first_item ? (item.target_units == 16'd0) : reached_q;
		total_n   = item.first_item ? '0 : total_q;
		sat_n     = item.first_item ? 1'b0 : sat_q;
		tot_sum   = {1'b0, total_n} + (CW + 1)'(item.unit_step);
		acc_sum   = {1'b0, accum_n} + (CW + 2)'(item.seq_len);

		if (item.has_byte) begin
			if (bytes_n == CMAX)
				sat_n = 1'b1;
			else
				bytes_n = bytes_n + 1'b1;
		end

		if (item.count_units) begin
			if (tot_sum[CW]) begin
				total_n = CMAX;
				sat_n   = 1'b1;
			end else begin
				total_n = tot_sum[CW-1:0];
			end
			if (!reached_n) begin
				if (acc_sum[CW+1]) begin
					accum_n = AMAX;
					sat_n   = 1'b1;
				end else begin
					accum_n = acc_sum[CW:0];
				end
				units_n = units_n - $signed({16'd0, item.unit_step});
				if (units_n <= 18'sd0)
					reached_n = 1'b1;
			end
		end
	end

	// result from the updated counters, clamped to the text length
	always_comb begin
		seen_ext = CMP_W'(bytes_n);
		if (mode == utf8pm_pkg::MODE_UTF8) begin
			off     = (units_n > 18'sd0) ? CMP_W'($unsigned(units_n)) : '0;
			ok      = 1'b1;
			tot_ext = CMP_W'(bytes_n);
		end else begin
			off     = CMP_W'(accum_n);
			ok      = reached_n && (units_n >= 18'sd0);
			tot_ext = CMP_W'(total_n);
		end
		if (off > seen_ext) begin
			off = seen_ext;
			ok  = 1'b0;
		end
	end

	// running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q   <= '0;
			offset_accum_q <= '0;
			units_left_q   <= '0;
			reached_q      <= 1'b0;
			total_q        <= '0;
			sat_q          <= 1'b0;
		end else if (pop) begin
			bytes_seen_q   <= bytes_n;
			offset_accum_q <= accum_n;
			units_left_q   <= units_n;
			reached_q      <= reached_n;
			total_q        <= total_n;
			sat_q          <= sat_n;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && item.last_item) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop && item.last_item) begin
			res_offset_q <= off[FW-1:0];
			res_ok_q     <= ok;
			res_count_q  <= tot_ext[FW-1:0];
			res_sat_q    <= sat_n;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.byte_offset     = res_offset_q;
	assign result.offset_valid    = res_ok_q;
	assign result.unit_count      = res_count_q;
	assign result.count_saturated = res_sat_q;

endmodule
